@@ design/mst_pkg.sv @@
`default_nettype none

package mst_pkg;

    // Tree geometry: node 1 is the root, leaf i sits at node LEAVES + i.
    localparam int LEAVES = 1024;
    localparam int LEAF_W = $clog2(LEAVES);
    localparam int NODES  = 2 * LEAVES;
    localparam int NODE_W = LEAF_W + 1;

    // Item field widths.
    localparam int POS_W = 10;
    localparam int END_W = 11;
    localparam int VAL_W = 32;

    // Bound counters must hold LEAVES + range_end and the node index plus one.
    localparam int CNT_W = (NODE_W + 1 > END_W + 1) ? NODE_W + 1 : END_W + 1;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_DATA_W = ((POS_W + END_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((VAL_W + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    // Item kinds carried on tuser.
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_step;
        logic load;
        logic upd_step;
        logic qry_step;
    } mst_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_last;
        logic upd_ok;
        logic walk_done;
        logic lo_lt_hi;
    } mst_stat_t;

endpackage

`default_nettype wire

@@ design/mst_dpath.sv @@
`default_nettype none

module mst_dpath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mst_pkg::mst_cmd_t          cmd,
    output mst_pkg::mst_stat_t              stat,
    input  wire logic [mst_pkg::POS_W-1:0]  in_pos,
    input  wire logic [mst_pkg::END_W-1:0]  in_end,
    input  wire logic [mst_pkg::VAL_W-1:0]  in_value,
    output logic      [mst_pkg::VAL_W-1:0]  max_value,
    output logic                            range_empty
);
    import mst_pkg::*;

    function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
        smax = ($signed(a) > $signed(b)) ? a : b;
    endfunction

    logic [VAL_W-1:0] mem [NODES];

    logic [NODE_W-1:0] addr_reg, addr_next;
    logic [NODE_W-1:0] waddr_reg;
    logic              pend_reg, pend_next;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [VAL_W-1:0]  acc_reg, acc_next;
    logic              use_a_reg, use_a_next;
    logic              use_b_reg, use_b_next;
    logic              empty_reg;
    logic [VAL_W-1:0]  rd_a_reg, rd_b_reg;

    logic [CNT_W-1:0]  pos_ext, end_ext, end_sat, leaves_c, leaf_node, hi_dec, lo_inc;
    logic [NODE_W-1:0] raddr_a, raddr_b, waddr;
    logic [VAL_W-1:0]  a_sel, b_sel, pair_max, wdata;
    logic              we, lo_lt_hi;

    always_comb
    begin
        leaves_c  = CNT_W'(LEAVES);
        pos_ext   = CNT_W'(in_pos);
        end_ext   = CNT_W'(in_end);
        end_sat   = (end_ext > leaves_c) ? leaves_c : end_ext;
        leaf_node = pos_ext + leaves_c;
        lo_lt_hi  = lo_reg < hi_reg;
        hi_dec    = hi_reg - CNT_W'(1);
        lo_inc    = lo_reg + CNT_W'(lo_reg[0]);

        raddr_a = cmd.qry_step ? lo_reg[NODE_W-1:0] : addr_reg;
        raddr_b = hi_dec[NODE_W-1:0];

        a_sel    = use_a_reg ? rd_a_reg : MOST_NEG;
        b_sel    = use_b_reg ? rd_b_reg : MOST_NEG;
        pair_max = smax(a_sel, b_sel);

        // Clearing pass writes zero; the walk raises each node on the path.
        we    = cmd.clear_step | (cmd.upd_step & pend_reg);
        waddr = cmd.clear_step ? addr_reg : waddr_reg;
        wdata = cmd.clear_step ? '0 : smax(rd_a_reg, val_reg);

        stat.clr_last  = (addr_reg == {NODE_W{1'b1}});
        stat.walk_done = (addr_reg == '0);
        stat.upd_ok    = (pos_ext < leaves_c);
        stat.lo_lt_hi  = lo_lt_hi;
    end

    always_comb
    begin
        addr_next  = addr_reg;
        pend_next  = pend_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        use_a_next = 1'b0;
        use_b_next = 1'b0;
        acc_next   = smax(acc_reg, pair_max);
        if (cmd.load)
        begin
            addr_next = leaf_node[NODE_W-1:0];
            pend_next = 1'b0;
            lo_next   = leaf_node;
            hi_next   = end_sat + leaves_c;
            acc_next  = MOST_NEG;
        end
        else if (cmd.clear_step)
        begin
            addr_next = addr_reg + NODE_W'(1);
        end
        else if (cmd.upd_step)
        begin
            addr_next = addr_reg >> 1;
            pend_next = (addr_reg != '0);
        end
        else if (cmd.qry_step && lo_lt_hi)
        begin
            use_a_next = lo_reg[0];
            use_b_next = hi_reg[0];
            lo_next    = lo_inc >> 1;
            hi_next    = hi_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
            use_a_reg <= 1'b0;
            use_b_reg <= 1'b0;
        end
        else
        begin
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
            use_a_reg <= use_a_next;
            use_b_reg <= use_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        acc_reg <= acc_next;
        if (cmd.load)
        begin
            val_reg   <= in_value;
            empty_reg <= (pos_ext >= end_sat);
        end
        if (cmd.upd_step)
        begin
            waddr_reg <= addr_reg;
        end
    end

    // Tree store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign max_value   = acc_reg;
    assign range_empty = empty_reg;

endmodule

`default_nettype wire

@@ design/mst_ctrl.sv @@
`default_nettype none

module mst_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_kind,
    output logic                    in_ready,
    input  wire mst_pkg::mst_stat_t stat,
    input  wire logic               out_free,
    output logic                    out_load,
    output mst_pkg::mst_cmd_t       cmd
);
    import mst_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_UPD   = 5'b00100,
        ST_QRY   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_kind == CMD_QUERY)
                    begin
                        state_next = ST_QRY;
                    end
                    else if (stat.upd_ok)
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                cmd.upd_step = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY:
            begin
                cmd.qry_step = 1'b1;
                if (!stat.lo_lt_hi)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ design/max_segment_tree_core.sv @@
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: position, range_end, value; tuser: cmd
// m_axis    out  m_axis_tvalid/tready       tdata: max_value; tuser: range_empty
//
// After reset the tree store is swept to zero, one node per cycle, with s_axis_tready
// low. Items are then taken one at a time.
// An update walks leaf to root, one read and one write of the tree store per level;
// it is skipped when position is off the tree.
// A query walks both bounds up one level per cycle using both read ports, then folds
// in the last nodes and hands the result to the output register.
// A finished query waits in the controller while m_axis is stalled; an earlier
// result sits in the output register without holding up the next item.
`default_nettype none

module max_segment_tree_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] position, [20:10] range_end, [52:21] value, [55:53] zero
    input  wire logic [mst_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // [0] cmd
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] max_value
    output logic      [mst_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // [0] range_empty
    output logic                                m_axis_tuser
);
    import mst_pkg::*;

    mst_cmd_t          cmd;
    mst_stat_t         stat;
    logic              out_free, out_load;
    logic [POS_W-1:0]  in_pos;
    logic [END_W-1:0]  in_end;
    logic [VAL_W-1:0]  in_value;
    logic [VAL_W-1:0]  dp_max;
    logic              dp_empty;

    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_data_reg;
    logic              m_empty_reg;

    // Unpack the input item, first field in the lowest bits.
    assign in_pos   = s_axis_tdata[POS_W-1:0];
    assign in_end   = s_axis_tdata[POS_W+END_W-1:POS_W];
    assign in_value = s_axis_tdata[POS_W+END_W+VAL_W-1:POS_W+END_W];

    mst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd)
    );

    mst_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_pos      (in_pos),
        .in_end      (in_end),
        .in_value    (in_value),
        .max_value   (dp_max),
        .range_empty (dp_empty)
    );

    // Output register: free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result payload until the next query completes.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg  <= dp_max;
            m_empty_reg <= dp_empty;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_DATA_W'(m_data_reg);
    assign m_axis_tuser  = m_empty_reg;

endmodule

`default_nettype wire

@@ design/mst_checker.sv @@
`default_nettype none

module mst_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    input  wire logic                         s_axis_tready,
    input  wire logic                         s_axis_tuser,
    input  wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    input  wire logic [mst_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  wire logic                         m_axis_tuser
);
    import mst_pkg::*;

    // A held result keeps its value until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // An empty range always reports the most negative value.
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[VAL_W-1:0] == MOST_NEG)
        else $error("empty range with a value other than most negative");

    // An accepted query keeps the block busy in the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_QUERY |=> !s_axis_tready)
        else $error("input taken straight after a query");

    // A new result only appears as the controller leaves its busy states.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while the block was idle");

endmodule

bind max_segment_tree_core mst_checker u_mst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/tb_max_segment_tree_core.sv @@
`default_nettype none

module tb_max_segment_tree_core;

    import mst_pkg::*;

    // Run length and watchdog: the reset sweep alone keeps s_axis_tready low while it
    // clears every node, so the idle limit sits well above that plus the longest stall.
    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_LIMIT   = 5 * NODES + 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 10;

    // One expected query result.
    typedef struct {
        logic signed [VAL_W-1:0] peak;
        logic                    empty;
    } peak_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [9:0] position, [20:10] range_end, [52:21] value, [55:53] zero
    logic [S_DATA_W-1:0]   s_axis_tdata;
    // [0] cmd
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [31:0] max_value
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // [0] range_empty
    logic                  m_axis_tuser;

    // Predictor state: our own copy of the tree, root at node 1.
    logic signed [VAL_W-1:0] tree_max [0:NODES-1];
    peak_t                   pending_peaks [$];

    int unsigned error_count;
    int unsigned update_count;
    int unsigned query_count;
    int unsigned empty_query_count;
    int unsigned checked_count;
    int unsigned burst_left;
    int unsigned last_pos;

    max_segment_tree_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Raise one leaf and rebuild every ancestor from its two children.
    function automatic void raise_leaf(input int unsigned pos, input logic [VAL_W-1:0] val);
        int                      k;
        logic signed [VAL_W-1:0] cand;
        cand = val;
        if (pos >= LEAVES)
            return;
        k = pos + LEAVES;
        if (cand > tree_max[k])
            tree_max[k] = cand;
        k = k >> 1;
        while (k >= 1)
        begin
            tree_max[k] = (tree_max[2*k] > tree_max[2*k+1]) ? tree_max[2*k] : tree_max[2*k+1];
            k = k >> 1;
        end
    endfunction

    // Maximum over the half-open leaf range [lo_in, hi_in), bound saturated to the tree.
    function automatic peak_t predict_peak(input int unsigned lo_in, input int unsigned hi_in);
        peak_t                   r;
        int unsigned             lo;
        int unsigned             hi;
        logic signed [VAL_W-1:0] acc;
        hi = (hi_in > LEAVES) ? LEAVES : hi_in;
        if (lo_in >= LEAVES || lo_in >= hi)
        begin
            r.peak  = MOST_NEG;
            r.empty = 1'b1;
            return r;
        end
        acc = MOST_NEG;
        lo  = lo_in + LEAVES;
        hi  = hi + LEAVES;
        while (lo < hi)
        begin
            if (lo[0])
            begin
                if (tree_max[lo] > acc)
                    acc = tree_max[lo];
                lo++;
            end
            if (hi[0])
            begin
                hi--;
                if (tree_max[hi] > acc)
                    acc = tree_max[hi];
            end
            lo = lo >> 1;
            hi = hi >> 1;
        end
        r.peak  = acc;
        r.empty = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------

    task automatic send_item(input logic cmd, input int unsigned pos,
                             input int unsigned bound, input logic [VAL_W-1:0] val);
        logic [S_DATA_W-1:0] word;
        int unsigned         gap;
        peak_t               exp_peak;
        word = '0;
        word[POS_W-1:0]                     = pos[POS_W-1:0];
        word[POS_W+END_W-1:POS_W]           = bound[END_W-1:0];
        word[POS_W+END_W+VAL_W-1:POS_W+END_W] = val;
        // Open a fresh burst with an idle gap in front of it; a gap of zero
        // keeps tvalid high straight through from the previous item.
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= cmd;
        // Hold the item until the block takes it.
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cmd == CMD_UPDATE)
        begin
            raise_leaf(pos[POS_W-1:0], val);
            update_count++;
        end
        else
        begin
            exp_peak = predict_peak(pos[POS_W-1:0], bound[END_W-1:0]);
            pending_peaks = {pending_peaks, exp_peak};
            query_count++;
            if (exp_peak.empty)
                empty_query_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, in one of four randomly chosen styles
    // ------------------------------------------------------------------

    int unsigned rx_cycle;
    int unsigned rx_mode;
    int unsigned rx_stall_left;

    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 256 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;                              // no stalls at all
            1: m_axis_tready <= ($urandom_range(0, 99) >= 40);     // random, ready six times in ten
            2: m_axis_tready <= ((rx_cycle % 11) >= 4);            // fixed beat
            default:
            begin
                // Rare long stalls.
                if (rx_stall_left > 0)
                begin
                    rx_stall_left--;
                    m_axis_tready <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    rx_stall_left = $urandom_range(5, 25);
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Checker: compare every result with the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        peak_t exp_peak;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_peaks.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: max_value %0d range_empty %0b",
                             $signed(m_axis_tdata[VAL_W-1:0]), m_axis_tuser);
            end
            else
            begin
                exp_peak = pending_peaks.pop_front();
                checked_count++;
                if (m_axis_tdata[VAL_W-1:0] !== exp_peak.peak || m_axis_tuser !== exp_peak.empty)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("result %0d: expected max_value %0d range_empty %0b, got %0d %0b",
                                 checked_count, exp_peak.peak, exp_peak.empty,
                                 $signed(m_axis_tdata[VAL_W-1:0]), m_axis_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which neither side moves an item
    // ------------------------------------------------------------------

    int unsigned idle_cycles;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries on the freshly cleared tree: every leaf reads as zero.
    task automatic test_cleared_tree();
        send_item(CMD_QUERY, 0, LEAVES, '0);
        send_item(CMD_QUERY, 5, 6, '0);
        send_item(CMD_QUERY, 7, 7, '0);            // empty range, equal bounds
        send_item(CMD_QUERY, 0, 2047, '0);         // right bound saturated to the tree
    endtask

    // Field extremes, raises that must not lower a leaf, and the empty cases.
    task automatic test_extremes();
        send_item(CMD_UPDATE, 0, 0, 32'h7FFF_FFFF);
        send_item(CMD_UPDATE, LEAVES - 1, 2047, MOST_NEG);  // below zero: leaf stays put
        send_item(CMD_UPDATE, LEAVES - 1, 0, 32'd1);
        send_item(CMD_UPDATE, 512, 0, 32'd100);
        send_item(CMD_UPDATE, 512, 0, 32'd50);              // smaller: no change
        send_item(CMD_UPDATE, 1, 0, 32'hFFFF_FFFF);         // minus one: no change
        send_item(CMD_QUERY, 0, 1, 32'hFFFF_FFFF);
        send_item(CMD_QUERY, LEAVES - 1, LEAVES, '0);
        send_item(CMD_QUERY, 1, LEAVES, '0);
        send_item(CMD_QUERY, 1, 2, '0);
        send_item(CMD_QUERY, 511, 513, '0);
        send_item(CMD_QUERY, 0, 0, '0);                     // empty at the left edge
        send_item(CMD_QUERY, LEAVES - 1, 0, '0);            // left bound above right
        send_item(CMD_QUERY, 1000, 2047, '0);
        send_item(CMD_QUERY, LEAVES - 1, 1025, '0);         // saturated, one leaf left
    endtask

    // Random mix of raises and queries, clustered so that ranges see real change.
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned         pos;
        int unsigned         bound;
        logic [VAL_W-1:0]    val;
        int unsigned         pick;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                pos = ($urandom_range(0, 1) == 0) ? 0 : LEAVES - 1;
            else if (pick < 5)
                pos = (last_pos + $urandom_range(0, 40)) % LEAVES;  // stay near recent work
            else
                pos = $urandom_range(0, LEAVES - 1);
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: val = $urandom;
                    1: val = $urandom_range(0, 1000);
                    2: val = $urandom | 32'h8000_0000;
                    default: val = 32'h7FFF_FF00 + $urandom_range(0, 255);
                endcase
                last_pos = pos;
                send_item(CMD_UPDATE, pos, $urandom_range(0, 2047), val);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: bound = pos + $urandom_range(1, 48);
                    4, 5, 6:    bound = $urandom_range(0, LEAVES);
                    7:          bound = $urandom_range(LEAVES, 2047);
                    8:          bound = $urandom_range(0, pos);       // empty
                    default:
                    begin
                        pos   = 0;
                        bound = $urandom_range(1, LEAVES);
                    end
                endcase
                if (bound > 2047)
                    bound = 2047;
                send_item(CMD_QUERY, pos, bound, $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_UPDATE;
        rst_n         = 1'b0;
        error_count   = 0;
        burst_left    = 0;
        last_pos      = 0;
        for (int k = 0; k < NODES; k++)
            tree_max[k] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_tree();
        test_extremes();
        test_random_mix(RANDOM_ITEMS);

        // Drop tvalid, drain the outstanding queries, then allow for an update
        // still climbing the tree.
        s_axis_tvalid <= 1'b0;
        while (pending_peaks.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        error_count += pending_peaks.size();
        $display("covered %0d raises and %0d queries (%0d empty), %0d results checked",
                 update_count, query_count, empty_query_count, checked_count);
        $display("errors: %0d", error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
